// ===== hw/rtl/dtsi_pkg.sv =====
// Package for the decimal text to scaled integer parser.
// Holds character codes, status codes, the parse phase type and the record
// passed from the character front end to the finishing back end. No dependencies.
`timescale 1ns / 1ps

package dtsi_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  localparam logic [7:0] SAT8 = 8'hFF;

  // Largest number of times ten that a nonzero magnitude could ever survive.
  localparam logic [10:0] MAX_SCALE = 11'd18;
  localparam logic signed [10:0] MAX_DECS = 11'sd127;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FIRST = 3'd1;
  localparam logic [2:0] ST_TWO_DOTS  = 3'd2;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
  localparam logic [2:0] ST_TOO_BIG   = 3'd4;
  localparam logic [2:0] ST_DEC_RANGE = 3'd5;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_SIGNED    = 3'd1,
    PH_BODY      = 3'd2,
    PH_EXP_START = 3'd3,
    PH_EXP       = 3'd4,
    PH_DONE      = 3'd5,
    PH_ERR       = 3'd6
  } phase_t;

  // Everything the back end needs to finish one number.
  typedef struct packed {
    logic        negative;
    logic [62:0] magnitude;
    logic [7:0]  after_dot_count;
    logic [7:0]  dropped_digits;
    logic [7:0]  exponent_value;
    logic        exponent_negative;
    logic [2:0]  error_code;
  } rec_t;

endpackage

// ===== hw/rtl/decimal_text_to_scaled_integer_top.sv =====
// Decimal text to scaled integer parser, top level. Depends on dtsi_pkg,
// dtsi_front, dtsi_queue and dtsi_back.
// Throughput: one character transaction per cycle while the queue has room; the
// front end parses as it goes. A negative decimal count is scaled away in the
// back end's scaling register, one times-ten per cycle, up to 18 times.
// Reset: rst_n is synchronous and active low; it clears the parse state, the queue
// and all valid flags at once, with no clearing pass.
`timescale 1ns / 1ps

module decimal_text_to_scaled_integer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        in_stall,
  output logic        out_valid,
  output logic [63:0] out_amount,
  output logic [6:0]  out_decimals,
  output logic [2:0]  out_status,
  input  logic        out_stall
);

  // Records of finished numbers travel from the front end to the back end
  // through a two-entry queue, so a long scaling run in the back end does not
  // hold up characters of the next number.
  dtsi_pkg::rec_t q_wdata;
  dtsi_pkg::rec_t q_rdata;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_nonempty;

  // The front end takes a character transaction whenever the queue has room.
  dtsi_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  dtsi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  // The back end computes the decimal count and status, scales when needed,
  // and owns the output register that parts it from the downstream side.
  dtsi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_amount   (out_amount),
    .out_decimals (out_decimals),
    .out_status   (out_status),
    .out_stall    (out_stall)
  );

endmodule

// ===== hw/rtl/dtsi_front.sv =====
// Character front end: parses one character per cycle unless the queue is full;
// on the last one, hands a finished parse record to the queue. Depends on dtsi_pkg.
`timescale 1ns / 1ps

module dtsi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_char_code,
  input  logic          in_last,
  output logic          in_stall,
  input  logic          q_full,
  output logic          q_push,
  output dtsi_pkg::rec_t q_wdata
);

  dtsi_pkg::phase_t phase_r, phase_nxt;
  logic        negative_r, negative_nxt;
  logic [62:0] mag_r, mag_nxt;
  logic        dot_r, dot_nxt;
  logic [7:0]  adc_r, adc_nxt;
  logic [7:0]  drop_r, drop_nxt;
  logic [7:0]  expv_r, expv_nxt;
  logic        expneg_r, expneg_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        accept;
  logic        is_digit;
  logic [3:0]  dig;
  logic [66:0] prod;
  logic        ovf;
  logic [11:0] ev;
  logic        do_body;
  logic        do_exp;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_last;

  assign is_digit = (in_char_code >= dtsi_pkg::CH_0) && (in_char_code <= dtsi_pkg::CH_9);
  assign dig      = 4'(in_char_code - dtsi_pkg::CH_0);
  // magnitude * 10 + digit; anything above 63 bits overflows.
  assign prod = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + 67'(dig);
  assign ovf  = |prod[66:63];
  assign ev   = ({4'b0, expv_r} << 3) + ({4'b0, expv_r} << 1) + 12'(dig);

  always_comb begin
    phase_nxt    = phase_r;
    negative_nxt = negative_r;
    mag_nxt      = mag_r;
    dot_nxt      = dot_r;
    adc_nxt      = adc_r;
    drop_nxt     = drop_r;
    expv_nxt     = expv_r;
    expneg_nxt   = expneg_r;
    err_nxt      = err_r;
    do_body      = 1'b0;
    do_exp       = 1'b0;

    case (phase_r)
      dtsi_pkg::PH_LEAD: begin
        if (in_char_code == dtsi_pkg::CH_SPACE) begin
          phase_nxt = phase_r;
        end else if (in_char_code == dtsi_pkg::CH_MINUS ||
                     in_char_code == dtsi_pkg::CH_PLUS) begin
          negative_nxt = (in_char_code == dtsi_pkg::CH_MINUS);
          phase_nxt    = dtsi_pkg::PH_SIGNED;
        end else if (in_char_code < dtsi_pkg::CH_0 && in_char_code != dtsi_pkg::CH_DOT) begin
          err_nxt   = dtsi_pkg::ST_BAD_FIRST;
          phase_nxt = dtsi_pkg::PH_ERR;
        end else begin
          do_body = 1'b1;
        end
      end
      dtsi_pkg::PH_SIGNED: begin
        do_body = (in_char_code != dtsi_pkg::CH_SPACE);
      end
      dtsi_pkg::PH_BODY: begin
        do_body = 1'b1;
      end
      dtsi_pkg::PH_EXP_START, dtsi_pkg::PH_EXP: begin
        do_exp = 1'b1;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    if (do_body) begin
      phase_nxt = dtsi_pkg::PH_BODY;
      if (in_char_code == dtsi_pkg::CH_DOT) begin
        if (dot_r) begin
          err_nxt   = dtsi_pkg::ST_TWO_DOTS;
          phase_nxt = dtsi_pkg::PH_ERR;
        end else begin
          dot_nxt = 1'b1;
        end
      end else if (in_char_code == dtsi_pkg::CH_E_UP || in_char_code == dtsi_pkg::CH_E_LO) begin
        phase_nxt = dtsi_pkg::PH_EXP_START;
      end else if (in_char_code == dtsi_pkg::CH_SPACE) begin
        phase_nxt = dtsi_pkg::PH_DONE;
      end else if (!is_digit) begin
        err_nxt   = dtsi_pkg::ST_BAD_CHAR;
        phase_nxt = dtsi_pkg::PH_ERR;
      end else begin
        if (dot_r) begin
          adc_nxt = (adc_r == dtsi_pkg::SAT8) ? adc_r : adc_r + 8'd1;
        end
        if (ovf) begin
          if (!dot_r) begin
            err_nxt   = dtsi_pkg::ST_TOO_BIG;
            phase_nxt = dtsi_pkg::PH_ERR;
          end else begin
            drop_nxt = (drop_r == dtsi_pkg::SAT8) ? drop_r : drop_r + 8'd1;
          end
        end else begin
          mag_nxt = prod[62:0];
        end
      end
    end

    if (do_exp) begin
      if (in_char_code == dtsi_pkg::CH_SPACE) begin
        phase_nxt = dtsi_pkg::PH_DONE;
      end else if (phase_r == dtsi_pkg::PH_EXP_START &&
                   (in_char_code == dtsi_pkg::CH_MINUS || in_char_code == dtsi_pkg::CH_PLUS)) begin
        expneg_nxt = (in_char_code == dtsi_pkg::CH_MINUS);
        phase_nxt  = dtsi_pkg::PH_EXP;
      end else if (!is_digit) begin
        err_nxt   = dtsi_pkg::ST_BAD_CHAR;
        phase_nxt = dtsi_pkg::PH_ERR;
      end else begin
        phase_nxt = dtsi_pkg::PH_EXP;
        expv_nxt  = (|ev[11:8]) ? dtsi_pkg::SAT8 : ev[7:0];
      end
    end
  end

  always_comb begin
    q_wdata.negative          = negative_nxt;
    q_wdata.magnitude         = mag_nxt;
    q_wdata.after_dot_count   = adc_nxt;
    q_wdata.dropped_digits    = drop_nxt;
    q_wdata.exponent_value    = expv_nxt;
    q_wdata.exponent_negative = expneg_nxt;
    q_wdata.error_code        = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      phase_r    <= dtsi_pkg::PH_LEAD;
      negative_r <= 1'b0;
      mag_r      <= '0;
      dot_r      <= 1'b0;
      adc_r      <= '0;
      drop_r     <= '0;
      expv_r     <= '0;
      expneg_r   <= 1'b0;
      err_r      <= dtsi_pkg::ST_OK;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      negative_r <= negative_nxt;
      mag_r      <= mag_nxt;
      dot_r      <= dot_nxt;
      adc_r      <= adc_nxt;
      drop_r     <= drop_nxt;
      expv_r     <= expv_nxt;
      expneg_r   <= expneg_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// ===== hw/rtl/dtsi_queue.sv =====
// Short queue of finished parse records between the front and back ends.
// Depends on dtsi_pkg for the record type and depth.
`timescale 1ns / 1ps

module dtsi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dtsi_pkg::rec_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output dtsi_pkg::rec_t rdata
);

  dtsi_pkg::rec_t mem_r [dtsi_pkg::Q_DEPTH];
  logic [dtsi_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dtsi_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dtsi_pkg::Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (dtsi_pkg::Q_PTR_W + 1)'(dtsi_pkg::Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (dtsi_pkg::Q_PTR_W + 1)'(push) - (dtsi_pkg::Q_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/dtsi_back.sv =====
// Finishing back end: works out the decimal count and status of a record,
// scales the magnitude by ten once a cycle when needed, and holds the result.
// Depends on dtsi_pkg.
`timescale 1ns / 1ps

module dtsi_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  dtsi_pkg::rec_t q_rdata,
  output logic           q_pop,
  output logic           out_valid,
  output logic [63:0]    out_amount,
  output logic [6:0]     out_decimals,
  output logic [2:0]     out_status,
  input  logic           out_stall
);

  logic        wk_v_r, wk_v_nxt;
  logic [62:0] wk_mag_r, wk_mag_nxt;
  logic        wk_neg_r, wk_neg_nxt;
  logic [4:0]  wk_steps_r, wk_steps_nxt;
  logic [2:0]  wk_st_r, wk_st_nxt;
  logic [6:0]  wk_dec_r, wk_dec_nxt;

  logic        out_valid_r;
  logic [63:0] out_amount_r;
  logic [6:0]  out_decimals_r;
  logic [2:0]  out_status_r;

  logic signed [10:0] d;
  logic [10:0]        k;
  logic [2:0]         ld_st;
  logic [6:0]         ld_dec;
  logic [4:0]         ld_steps;
  logic [66:0]        prod;
  logic               ovf;
  logic               out_free;
  logic               wk_done;
  logic               move;
  logic               wk_free;

  assign out_free = !out_valid_r || !out_stall;
  assign wk_done  = wk_v_r && (wk_steps_r == '0);
  assign move     = wk_done && out_free;
  assign wk_free  = !wk_v_r || move;
  assign q_pop    = q_nonempty && wk_free;

  // Decimal count: digits kept after the dot minus the signed exponent.
  always_comb begin
    d = $signed({3'b0, q_rdata.after_dot_count}) - $signed({3'b0, q_rdata.dropped_digits});
    if (q_rdata.exponent_negative) begin
      d = d + $signed({3'b0, q_rdata.exponent_value});
    end else begin
      d = d - $signed({3'b0, q_rdata.exponent_value});
    end
    k        = 11'(-d);
    ld_st    = q_rdata.error_code;
    ld_dec   = '0;
    ld_steps = '0;
    if (q_rdata.error_code == dtsi_pkg::ST_OK) begin
      if (q_rdata.after_dot_count == dtsi_pkg::SAT8 || d > dtsi_pkg::MAX_DECS) begin
        ld_st = dtsi_pkg::ST_DEC_RANGE;
      end else if (d < 0) begin
        if (q_rdata.magnitude != '0) begin
          if (k > dtsi_pkg::MAX_SCALE) begin
            ld_st = dtsi_pkg::ST_TOO_BIG;
          end else begin
            ld_steps = k[4:0];
          end
        end
      end else begin
        ld_dec = d[6:0];
      end
    end
  end

  // Ten times a 63-bit magnitude needs 67 bits to hold without wrapping.
  assign prod = ({4'b0, wk_mag_r} << 3) + ({4'b0, wk_mag_r} << 1);
  assign ovf  = |prod[66:63];

  always_comb begin
    wk_v_nxt     = wk_v_r;
    wk_mag_nxt   = wk_mag_r;
    wk_neg_nxt   = wk_neg_r;
    wk_steps_nxt = wk_steps_r;
    wk_st_nxt    = wk_st_r;
    wk_dec_nxt   = wk_dec_r;
    if (q_pop) begin
      wk_v_nxt     = 1'b1;
      wk_mag_nxt   = q_rdata.magnitude;
      wk_neg_nxt   = q_rdata.negative;
      wk_steps_nxt = ld_steps;
      wk_st_nxt    = ld_st;
      wk_dec_nxt   = ld_dec;
    end else if (move) begin
      wk_v_nxt = 1'b0;
    end else if (wk_v_r && wk_steps_r != '0) begin
      if (ovf) begin
        wk_st_nxt    = dtsi_pkg::ST_TOO_BIG;
        wk_steps_nxt = '0;
      end else begin
        wk_mag_nxt   = prod[62:0];
        wk_steps_nxt = wk_steps_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_v_r <= 1'b0;
    end else begin
      wk_v_r <= wk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_mag_r   <= wk_mag_nxt;
    wk_neg_r   <= wk_neg_nxt;
    wk_steps_r <= wk_steps_nxt;
    wk_st_r    <= wk_st_nxt;
    wk_dec_r   <= wk_dec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_status_r <= wk_st_r;
      if (wk_st_r == dtsi_pkg::ST_OK) begin
        out_amount_r   <= wk_neg_r ? 64'd0 - {1'b0, wk_mag_r} : {1'b0, wk_mag_r};
        out_decimals_r <= wk_dec_r;
      end else begin
        out_amount_r   <= '0;
        out_decimals_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_amount   = out_amount_r;
  assign out_decimals = out_decimals_r;
  assign out_status   = out_status_r;

endmodule

// ===== hw/rtl/dtsi_checker.sv =====
// Port-level checks for the decimal text to scaled integer parser, and the
// bind that attaches them to the top level. Depends on dtsi_pkg.
`timescale 1ns / 1ps

module dtsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [63:0] out_amount,
  input logic [6:0]  out_decimals,
  input logic [2:0]  out_status,
  input logic        out_stall
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_amount) &&
      $stable(out_decimals) && $stable(out_status))
    else $error("result changed while stalled");

  // A failed parse carries a zero value and zero decimals.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dtsi_pkg::ST_OK |-> out_amount == '0 && out_decimals == '0)
    else $error("nonzero payload with error status");

  // Status is one of the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= dtsi_pkg::ST_DEC_RANGE)
    else $error("undefined status code");

  // The magnitude is 63 bits, so the most negative 64-bit value never appears.
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_amount != 64'h8000_0000_0000_0000)
    else $error("amount outside the signed magnitude range");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind decimal_text_to_scaled_integer_top dtsi_checker u_dtsi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_amount   (out_amount),
  .out_decimals (out_decimals),
  .out_status   (out_status),
  .out_stall    (out_stall)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for decimal_text_to_scaled_integer_top.
// It predicts each parsed number from the characters it sends and checks every
// result transaction field by field. Depends on dtsi_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;

  // The run is cut off after this many nanoseconds if it has not ended.
  localparam int RUN_LIMIT_NS = 2_000_000;
  // Cycles to wait after the last expected result for stray output.
  localparam int TAIL_CYCLES = 40;
  localparam int DRAIN_LIMIT = 5000;
  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  // One finished number as the parser reports it.
  typedef struct packed {
    logic [63:0] amount;
    logic [6:0]  decimals;
    logic [2:0]  status;
  } number_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_last = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] out_amount;
  logic [6:0]  out_decimals;
  logic [2:0]  out_status;
  logic        out_stall = 1'b0;

  // Idle rates in percent: gaps on the character side, stalls on the result side.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  // Numbers that have had their last character accepted, oldest first.
  number_result_t pending_numbers[$];

  // Parse state of the number currently being read.
  dtsi_pkg::phase_t num_phase;
  logic        num_negative;
  logic [62:0] num_mag;
  logic        num_dot;
  logic [7:0]  frac_count;
  logic [7:0]  dropped_count;
  logic [7:0]  exp_value;
  logic        exp_negative;
  logic [2:0]  err_code;

  decimal_text_to_scaled_integer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_last     (in_last),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_amount  (out_amount),
    .out_decimals(out_decimals),
    .out_status  (out_status),
    .out_stall   (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hang guard: a run that has not finished by now has lost a transaction.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the parser.
  // ---------------------------------------------------------------------------

  function automatic void clear_number();
    num_phase     = dtsi_pkg::PH_LEAD;
    num_negative  = 1'b0;
    num_mag       = '0;
    num_dot       = 1'b0;
    frac_count    = '0;
    dropped_count = '0;
    exp_value     = '0;
    exp_negative  = 1'b0;
    err_code      = dtsi_pkg::ST_OK;
  endfunction

  // The first error sticks; everything up to the last character is then ignored.
  function automatic void flag_error(logic [2:0] code);
    err_code  = code;
    num_phase = dtsi_pkg::PH_ERR;
  endfunction

  // The digit counters stop at their top value instead of wrapping.
  function automatic logic [7:0] bump(logic [7:0] count);
    return (count == dtsi_pkg::SAT8) ? dtsi_pkg::SAT8 : count + 8'd1;
  endfunction

  // One character of the number body: a digit, the dot, an exponent mark or
  // the space that ends the number.
  function automatic void take_body_char(logic [7:0] c);
    logic [63:0] digit;
    num_phase = dtsi_pkg::PH_BODY;
    if (c == dtsi_pkg::CH_DOT) begin
      if (num_dot) begin
        flag_error(dtsi_pkg::ST_TWO_DOTS);
      end else begin
        num_dot = 1'b1;
      end
    end else if (c == dtsi_pkg::CH_E_UP || c == dtsi_pkg::CH_E_LO) begin
      num_phase = dtsi_pkg::PH_EXP_START;
    end else if (c == dtsi_pkg::CH_SPACE) begin
      num_phase = dtsi_pkg::PH_DONE;
    end else if (c < dtsi_pkg::CH_0 || c > dtsi_pkg::CH_9) begin
      flag_error(dtsi_pkg::ST_BAD_CHAR);
    end else begin
      digit = {56'd0, c - dtsi_pkg::CH_0};
      if (num_dot) frac_count = bump(frac_count);
      // A digit that no longer fits is fatal before the dot; after it, the
      // digit is dropped and one decimal is given up for it.
      if ({1'b0, num_mag} > (MAG_LIMIT - digit) / 64'd10) begin
        if (!num_dot) begin
          flag_error(dtsi_pkg::ST_TOO_BIG);
        end else begin
          dropped_count = bump(dropped_count);
        end
      end else begin
        num_mag = 63'({1'b0, num_mag} * 64'd10 + digit);
      end
    end
  endfunction

  // Advances the parse by one accepted character. Returns 1, with the number
  // in res, when the character is the last one of its text.
  function automatic bit parse_char(logic [7:0] c, logic is_last,
                                    output number_result_t res);
    int          exp_sum;
    int          kept;
    int          shift;
    int          decs;
    logic [63:0] mag;
    logic [63:0] mult;
    logic [2:0]  st;
    res = '0;
    case (num_phase)
      dtsi_pkg::PH_LEAD: begin
        if (c != dtsi_pkg::CH_SPACE) begin
          if (c == dtsi_pkg::CH_MINUS || c == dtsi_pkg::CH_PLUS) begin
            num_negative = (c == dtsi_pkg::CH_MINUS);
            num_phase    = dtsi_pkg::PH_SIGNED;
          end else if (c < dtsi_pkg::CH_0 && c != dtsi_pkg::CH_DOT) begin
            flag_error(dtsi_pkg::ST_BAD_FIRST);
          end else begin
            take_body_char(c);
          end
        end
      end
      dtsi_pkg::PH_SIGNED: begin
        // Spaces between the sign and the digits are allowed.
        if (c != dtsi_pkg::CH_SPACE) take_body_char(c);
      end
      dtsi_pkg::PH_BODY: take_body_char(c);
      dtsi_pkg::PH_EXP_START, dtsi_pkg::PH_EXP: begin
        if (c == dtsi_pkg::CH_SPACE) begin
          num_phase = dtsi_pkg::PH_DONE;
        end else if (num_phase == dtsi_pkg::PH_EXP_START &&
                     (c == dtsi_pkg::CH_MINUS || c == dtsi_pkg::CH_PLUS)) begin
          exp_negative = (c == dtsi_pkg::CH_MINUS);
          num_phase    = dtsi_pkg::PH_EXP;
        end else if (c < dtsi_pkg::CH_0 || c > dtsi_pkg::CH_9) begin
          flag_error(dtsi_pkg::ST_BAD_CHAR);
        end else begin
          num_phase = dtsi_pkg::PH_EXP;
          exp_sum   = int'(exp_value) * 10 + int'(c - dtsi_pkg::CH_0);
          exp_value = (exp_sum > 255) ? dtsi_pkg::SAT8 : exp_sum[7:0];
        end
      end
      default: ;
    endcase

    if (!is_last) return 1'b0;

    st = err_code;
    if (st == dtsi_pkg::ST_OK) begin
      kept  = int'(frac_count) - int'(dropped_count);
      shift = exp_negative ? -int'(exp_value) : int'(exp_value);
      decs  = kept - shift;
      mag   = {1'b0, num_mag};
      if (frac_count == dtsi_pkg::SAT8 || decs > 127) begin
        st = dtsi_pkg::ST_DEC_RANGE;
      end else if (decs < 0) begin
        // A negative decimal count is scaled away into the value itself.
        if (mag != 64'd0) begin
          if (-decs > 18) begin
            st = dtsi_pkg::ST_TOO_BIG;
          end else begin
            mult = 64'd1;
            for (int i = 0; i < -decs; i++) mult = mult * 64'd10;
            if (mag > MAG_LIMIT / mult) begin
              st = dtsi_pkg::ST_TOO_BIG;
            end else begin
              mag = mag * mult;
            end
          end
        end
        decs = 0;
      end
      if (st == dtsi_pkg::ST_OK) begin
        res.amount   = num_negative ? (64'd0 - mag) : mag;
        res.decimals = decs[6:0];
      end
    end
    res.status = st;
    clear_number();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Transactions on both channels.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one character. valid stays high from one transaction to the next
  // and is only lowered during a gap, so it never gets two assignments in a step.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    number_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last      <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_char(c, is_last, res)) pending_numbers.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Result side: every accepted result is checked against the oldest pending
  // number, and the stall for the next cycle is drawn here.
  always @(posedge clk) begin
    number_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("result with nothing pending", out_amount, 64'd0);
      end else begin
        want = pending_numbers.pop_front();
        if (out_amount !== want.amount) report_mismatch("amount", out_amount, want.amount);
        if (out_decimals !== want.decimals)
          report_mismatch("decimals", 64'(out_decimals), 64'(want.decimals));
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Ordinary numbers, with and without a fraction, and negative zero.
  task automatic test_plain_numbers();
    send_text("0");
    send_text("-0");
    send_text("123.4500");
    send_text(".5");
    send_text("12 34");
  endtask

  // Leading spaces, signs, spaces after the sign, and texts with no digits.
  task automatic test_signs_and_spaces();
    send_text("  -  17.25");
    send_text("+42");
    send_text(" ");
    send_text("-");
    send_text("-.");
  endtask

  // The bad-first-character, two-dot and bad-character errors of the character stream.
  task automatic test_bad_text();
    send_text("!5");
    send_text("/");
    send_text("~");
    send_text("+-3");
    send_text("1.2.3");
    send_text("12a");
    send_text("1e+-2");
    send_text("3e5x");
  endtask

  // Exponent forms, including a missing exponent and a terminating space.
  task automatic test_exponent_forms();
    send_text("1.5e3");
    send_text("2E-2");
    send_text("7e+18");
    send_text("e5");
    send_text("1.5e");
    send_text("3e5 x!");
  endtask

  // Edges of the magnitude, of the scaling and of the decimal count.
  task automatic test_range_limits();
    string s;
    send_text("9223372036854775807");
    send_text("-9223372036854775807");
    send_text("9223372036854775808");
    send_text("0.92233720368547758079");
    send_text("1e19");
    send_text("10e18");
    send_text("0e40");
    send_text("1e-127");
    send_text("1e-128");
    send_text("1e999");
    // The fraction counter reaching its top value.
    s = "0.";
    repeat (255) s = {s, "0"};
    send_text(s);
    // A long fraction whose last digits no longer fit and are dropped.
    s = "1.";
    repeat (30) s = {s, "7"};
    send_text(s);
  endtask

  // Random texts until about char_budget characters have been sent. Most are
  // well-formed numbers with random content, some are damaged and the rest
  // are plain noise over the whole byte range.
  task automatic test_random_numbers(input int char_budget);
    logic [7:0] text[$];
    int         sent;
    int         n;
    sent = 0;
    while (sent < char_budget) begin
      text.delete();
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(2)) text.push_back(dtsi_pkg::CH_SPACE);
        case ($urandom_range(3))
          0: text.push_back(dtsi_pkg::CH_MINUS);
          1: text.push_back(dtsi_pkg::CH_PLUS);
          default: ;
        endcase
        if (text.size() > 0 && $urandom_range(5) == 0) text.push_back(dtsi_pkg::CH_SPACE);
        // Now and then enough digits to overflow the integral part.
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 21) : $urandom_range(0, 5);
        repeat (n) text.push_back(dtsi_pkg::CH_0 + 8'($urandom_range(9)));
        if ($urandom_range(2) != 0) begin
          text.push_back(dtsi_pkg::CH_DOT);
          n = ($urandom_range(7) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 5);
          repeat (n) text.push_back(dtsi_pkg::CH_0 + 8'($urandom_range(9)));
        end
        if ($urandom_range(3) == 0) begin
          text.push_back($urandom_range(1) ? dtsi_pkg::CH_E_UP : dtsi_pkg::CH_E_LO);
          case ($urandom_range(2))
            0: text.push_back(dtsi_pkg::CH_MINUS);
            1: text.push_back(dtsi_pkg::CH_PLUS);
            default: ;
          endcase
          n = ($urandom_range(7) == 0) ? 3 : $urandom_range(0, 2);
          repeat (n) text.push_back(dtsi_pkg::CH_0 + 8'($urandom_range(9)));
        end
        if ($urandom_range(5) == 0) begin
          text.push_back(dtsi_pkg::CH_SPACE);
          repeat ($urandom_range(3)) text.push_back(8'($urandom_range(255)));
        end
        if (text.size() == 0) text.push_back(dtsi_pkg::CH_0 + 8'($urandom_range(9)));
        // Damage a few: a random byte somewhere, or an extra dot.
        case ($urandom_range(11))
          0: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
          1: text.insert($urandom_range(text.size()), dtsi_pkg::CH_DOT);
          default: ;
        endcase
      end
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
      sent += text.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    int             waited;
    number_result_t lost;
    clear_number();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rare gaps on the character side against a receiver that stalls often.
    send_gap_pct   = 11;
    recv_stall_pct = 72;
    test_plain_numbers();
    test_signs_and_spaces();
    test_bad_text();
    test_exponent_forms();
    test_range_limits();
    test_random_numbers(60);

    // The other way round: a slow sender and a mostly ready receiver.
    send_gap_pct   = 72;
    recv_stall_pct = 11;
    test_random_numbers(60);

    // Back to back with no idling at all.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_numbers(50);

    in_valid <= 1'b0;
    waited = 0;
    while (pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    // Anything still pending never came out.
    while (pending_numbers.size() != 0) begin
      lost = pending_numbers.pop_front();
      report_mismatch("missing result, status", 64'd0, 64'(lost.status));
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
